[design/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg - shared definitions for the positional array list
// Widths, command and status codes, cell operations and the control word
// broadcast along the row of list cells.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int WORD_W = DATA_WIDTH;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = 7;
  localparam int CMD_W  = 3;
  localparam int STS_W  = 3;
  localparam int EXT_W  = 32;
  // width that holds both a position and count + 1
  localparam int CMP_W  = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  // reduction tree: groups of GRP cells, then one final group
  localparam int GRP    = 8;
  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADPOS   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_LOOK
  } cell_op_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WAIT1,
    FSM_WAIT2,
    FSM_FIN
  } fsm_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  tgt;   // 0-based target position
    logic [CNT_W-1:0]  cnt;   // entries held, for the valid limit
    logic [WORD_W-1:0] key;   // word to insert or key to compare
  } cell_ctrl_t;

endpackage

[design/pal_cell.sv]
// ----------------------------------------------------------------------------
// pal_cell - one list entry
// Holds one word; takes its left or right neighbour's word on insert or
// delete, and registers its compare hit and read word on a look-up.
// ----------------------------------------------------------------------------
module pal_cell (
  input  logic                      clk,
  input  pal_pkg::cell_ctrl_t       ctrl,
  input  logic [pal_pkg::IDX_W-1:0] my_idx,
  input  logic [pal_pkg::WORD_W-1:0] prev_data,
  input  logic [pal_pkg::WORD_W-1:0] next_data,
  output logic [pal_pkg::WORD_W-1:0] data,
  output logic                      hit,
  output logic [pal_pkg::WORD_W-1:0] rd
);
  import pal_pkg::*;

  logic [WORD_W-1:0] data_r, data_nxt;
  logic              hit_r, hit_nxt;
  logic [WORD_W-1:0] rd_r, rd_nxt;
  logic              held;

  assign held = {1'b0, my_idx} < (IDX_W + 1)'(ctrl.cnt);

  always_comb begin
    data_nxt = data_r;
    hit_nxt  = hit_r;
    rd_nxt   = rd_r;
    unique case (ctrl.op)
      OP_INS: begin
        if (my_idx > ctrl.tgt) begin
          data_nxt = prev_data;
        end else if (my_idx == ctrl.tgt) begin
          data_nxt = ctrl.key;
        end
      end
      OP_DEL: begin
        if (my_idx >= ctrl.tgt) begin
          data_nxt = next_data;
        end
      end
      OP_LOOK: begin
        hit_nxt = held && (data_r == ctrl.key);
        rd_nxt  = (my_idx == ctrl.tgt) ? data_r : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
    rd_r   <= rd_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;
  assign rd   = rd_r;

endmodule

[design/pal_tree.sv]
// ----------------------------------------------------------------------------
// pal_tree - registered OR tree over the cell row
// Two register levels: groups of cells, then the group results.
// ----------------------------------------------------------------------------
module pal_tree (
  input  logic                       clk,
  input  logic [pal_pkg::CAPACITY-1:0] hit,
  input  logic [pal_pkg::WORD_W-1:0] rd [pal_pkg::CAPACITY],
  output logic                       any_hit,
  output logic [pal_pkg::WORD_W-1:0] rd_word
);
  import pal_pkg::*;

  logic [NGRP-1:0]   grp_hit_r, grp_hit_nxt;
  logic [WORD_W-1:0] grp_rd_r   [NGRP];
  logic [WORD_W-1:0] grp_rd_nxt [NGRP];
  logic              any_hit_r, any_hit_nxt;
  logic [WORD_W-1:0] rd_word_r, rd_word_nxt;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_rd_nxt[g]  = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_hit_nxt[g] = grp_hit_nxt[g] | hit[g * GRP + k];
          grp_rd_nxt[g]  = grp_rd_nxt[g] | rd[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    any_hit_nxt = |grp_hit_r;
    rd_word_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word_nxt = rd_word_nxt | grp_rd_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_hit_r <= grp_hit_nxt;
    grp_rd_r  <= grp_rd_nxt;
    any_hit_r <= any_hit_nxt;
    rd_word_r <= rd_word_nxt;
  end

  assign any_hit = any_hit_r;
  assign rd_word = rd_word_r;

endmodule

[design/positional_array_list_core.sv]
// ----------------------------------------------------------------------------
// positional_array_list_core - fixed-capacity ordered list of signed words
// Clear, insert at a position, delete at a position, search for a key and
// read at a position, built as a row of shift cells with an OR tree.
// ----------------------------------------------------------------------------
//
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+------------------------
//  input   | in_command, in_position, in_value         | start high, busy low
//  result  | out_status, out_read_data, out_entry_count | out_valid, one cycle
//
// Clear, insert, delete, an error of any command and an unknown command
// give their result word in the cycle after the accept, and busy stays
// low. A search or read that passes its checks goes through the cell
// compare, two levels of the OR tree and the result register; busy is
// high after the accept until the result word is loaded.
// Reset (rst_n low, synchronous) empties the list; cell contents are not
// cleared, as only entries below the count are ever looked at.
// The receiver cannot stall: each result word is valid for exactly one cycle.
//
module positional_array_list_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pal_pkg::CMD_W-1:0]  in_command,
  input  logic [pal_pkg::POS_W-1:0]  in_position,
  input  logic signed [31:0]         in_value,
  output logic                       out_valid,
  output logic [pal_pkg::STS_W-1:0]  out_status,
  output logic signed [31:0]         out_read_data,
  output logic [pal_pkg::POS_W-1:0]  out_entry_count
);
  import pal_pkg::*;

  // control state
  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             is_search_r, is_search_nxt;

  // result word register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  // cell row
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] cell_data [CAPACITY];
  logic [WORD_W-1:0] cell_rd   [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic              any_hit;
  logic [WORD_W-1:0] rd_word;

  // command decode
  logic             accept;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             is_empty, is_full;
  logic             pos_ins_ok, pos_ok;

  assign accept   = start && (state_r == FSM_IDLE);
  assign pos_x    = CMP_W'(in_position);
  assign cnt_x    = CMP_W'(count_r);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  // insert may go one past the last entry, delete and read may not
  assign pos_ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign pos_ok     = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    is_search_nxt  = is_search_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_count_nxt  = out_count_r;
    ctrl.op        = OP_HOLD;
    ctrl.tgt       = IDX_W'(pos_x - CMP_W'(1));
    ctrl.cnt       = count_r;
    ctrl.key       = WORD_W'($unsigned(in_value));

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          // default: an immediate result word next cycle
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_word_nxt   = '0;
          case (in_command)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_INSERT: begin
              if (is_full) begin
                out_status_nxt = STS_FULL;
              end else if (!pos_ins_ok) begin
                out_status_nxt = STS_BADPOS;
              end else begin
                ctrl.op   = OP_INS;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (is_empty) begin
                out_status_nxt = STS_EMPTY;
              end else if (!pos_ok) begin
                out_status_nxt = STS_BADPOS;
              end else begin
                ctrl.op   = OP_DEL;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_SEARCH: begin
              if (is_empty) begin
                out_status_nxt = STS_EMPTY;
              end else begin
                // hold the result until the tree has settled
                ctrl.op       = OP_LOOK;
                out_valid_nxt = 1'b0;
                is_search_nxt = 1'b1;
                state_nxt     = FSM_WAIT1;
              end
            end
            CMD_READ: begin
              if (is_empty) begin
                out_status_nxt = STS_EMPTY;
              end else if (!pos_ok) begin
                out_status_nxt = STS_BADPOS;
              end else begin
                ctrl.op       = OP_LOOK;
                out_valid_nxt = 1'b0;
                is_search_nxt = 1'b0;
                state_nxt     = FSM_WAIT1;
              end
            end
            default: begin
              out_status_nxt = STS_BADPOS;
            end
          endcase
          out_count_nxt = count_nxt;
        end
      end
      FSM_WAIT1: begin
        state_nxt = FSM_WAIT2;
      end
      FSM_WAIT2: begin
        state_nxt = FSM_FIN;
      end
      FSM_FIN: begin
        // tree output is settled: load the result word
        out_valid_nxt = 1'b1;
        out_count_nxt = count_r;
        if (is_search_r) begin
          out_status_nxt = any_hit ? STS_OK : STS_NOTFOUND;
          out_word_nxt   = '0;
        end else begin
          out_status_nxt = STS_OK;
          out_word_nxt   = rd_word;
        end
        state_nxt = FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_search_r  <= is_search_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_count_r  <= out_count_nxt;
  end

  // row of cells; each end feeds itself back where it has no neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = cell_data[i];
    end else begin : g_mid_p
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = cell_data[i];
    end else begin : g_mid_n
      assign next_w = cell_data[i+1];
    end

    pal_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .my_idx    (IDX_W'(i)),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i]),
      .hit       (cell_hit[i]),
      .rd        (cell_rd[i])
    );
  end

  pal_tree u_tree (
    .clk     (clk),
    .hit     (cell_hit),
    .rd      (cell_rd),
    .any_hit (any_hit),
    .rd_word (rd_word)
  );

  assign busy            = (state_r != FSM_IDLE);
  assign out_valid       = out_valid_r && rst_n;
  assign out_status      = out_status_r;
  // sign-extend or truncate the stored word to the port
  assign out_read_data   = EXT_W'($signed(out_word_r));
  assign out_entry_count = POS_W'(out_count_r);

endmodule
